>>> design/rgbyuv_pkg.sv
// ----------------------------------------------------------------------------
// rgbyuv_pkg
// Types, coefficients and helpers shared by the RGB to YUV 4:2:0 converter.
// ----------------------------------------------------------------------------
package rgbyuv_pkg;

	localparam int PIX_W        = 8;
	localparam int CFG_W        = 13;
	localparam int PAIR_W       = 9;
	localparam int BLK_W        = 10;
	localparam int LINE_W       = 3 * PAIR_W;
	localparam int PROD_W       = 25;
	localparam int ACC_W        = 28;
	localparam int CHROMA_SHIFT = 18;
	localparam int LUMA_SHIFT   = 16;
	localparam int FIFO_DEPTH   = 8;
	localparam int FIFO_PW      = 3;

	localparam logic [0:0] REG_IMAGE_WIDTH  = 1'b0;
	localparam logic [0:0] REG_IMAGE_HEIGHT = 1'b1;

	localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd640;
	localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd480;

	localparam logic [15:0] Y_R = 16'd16839;
	localparam logic [15:0] Y_G = 16'd33059;
	localparam logic [15:0] Y_B = 16'd6420;
	localparam logic [15:0] U_R = 16'd9719;
	localparam logic [15:0] U_G = 16'd19081;
	localparam logic [15:0] U_B = 16'd28800;
	localparam logic [15:0] V_R = 16'd28800;
	localparam logic [15:0] V_G = 16'd24116;
	localparam logic [15:0] V_B = 16'd4684;

	localparam logic [PROD_W-1:0] Y_OFFSET = PROD_W'(32768 + (16 << 16));
	localparam logic [ACC_W-1:0]  C_OFFSET = ACC_W'(131072 + (128 << 18));

	typedef struct packed {
		logic              valid;
		logic [PIX_W-1:0]  red;
		logic [PIX_W-1:0]  green;
		logic [PIX_W-1:0]  blue;
		logic [PIX_W-1:0]  alpha;
		logic [PAIR_W-1:0] pair_r;
		logic [PAIR_W-1:0] pair_g;
		logic [PAIR_W-1:0] pair_b;
		logic              odd_row;
		logic              emit;
		logic              seen;
		logic              frame_end;
	} rgbyuv_s1_t;

	typedef struct packed {
		logic             frame_end;
		logic             seen;
		logic             chroma_valid;
		logic [PIX_W-1:0] chroma_v;
		logic [PIX_W-1:0] chroma_u;
		logic [PIX_W-1:0] alpha;
		logic [PIX_W-1:0] luma;
	} rgbyuv_res_t;

	function automatic logic [PIX_W-1:0] chroma_clip(input logic signed [ACC_W-1:0] acc);
		logic [PIX_W-1:0] res;
		if (acc[ACC_W-1]) begin
			res = '0;
		end else if (|acc[ACC_W-2:CHROMA_SHIFT+PIX_W]) begin
			res = '1;
		end else begin
			res = acc[CHROMA_SHIFT+PIX_W-1:CHROMA_SHIFT];
		end
		return res;
	endfunction

endpackage

>>> design/rgbyuv_ram.sv
// ----------------------------------------------------------------------------
// rgbyuv_ram
// Generic simple dual-port RAM with one write port and a registered read port.
// ----------------------------------------------------------------------------
module rgbyuv_ram #(
	parameter int  WIDTH = 27,
	parameter int  DEPTH = 2048,
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> design/rgbyuv_front.sv
// ----------------------------------------------------------------------------
// rgbyuv_front
// Size registers, pixel position, horizontal pairing and the line store of
// even-row pair sums.
// ----------------------------------------------------------------------------
module rgbyuv_front #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [0:0]                         cfg_index,
	input  logic [rgbyuv_pkg::CFG_W-1:0]       cfg_data,
	input  logic                               accept,
	input  logic [rgbyuv_pkg::PIX_W-1:0]       red,
	input  logic [rgbyuv_pkg::PIX_W-1:0]       green,
	input  logic [rgbyuv_pkg::PIX_W-1:0]       blue,
	input  logic [rgbyuv_pkg::PIX_W-1:0]       alpha,
	output rgbyuv_pkg::rgbyuv_s1_t             stage_s1,
	output logic [rgbyuv_pkg::LINE_W-1:0]      line_rdata
);

	import rgbyuv_pkg::*;

	localparam int CW         = $clog2(MAX_WIDTH);
	localparam int RW         = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int WSW        = CW + 1;
	localparam int HSW        = RW + 1;
	localparam int WEW        = (WSW > CFG_W) ? WSW : CFG_W;
	localparam int HEW        = (HSW > CFG_W) ? HSW : CFG_W;
	localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
	localparam int AW         = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

	logic [CFG_W-1:0]  width_q;
	logic [CFG_W-1:0]  height_q;
	logic [CW-1:0]     col_q;
	logic [RW-1:0]     row_q;
	logic [PIX_W-1:0]  pend_r_q;
	logic [PIX_W-1:0]  pend_g_q;
	logic [PIX_W-1:0]  pend_b_q;
	logic              flag_q;

	logic [WEW-1:0]    w_ext;
	logic [HEW-1:0]    h_ext;
	logic [WSW-1:0]    w_eff;
	logic [HSW-1:0]    h_eff;
	logic              last_col;
	logic              last_row;
	logic              even_col;
	logic              even_row;
	logic              pair_done;
	logic [PAIR_W-1:0] pr;
	logic [PAIR_W-1:0] pg;
	logic [PAIR_W-1:0] pb;
	logic              seen;
	logic              store;
	logic [AW-1:0]     line_addr;

	always_comb begin
		w_ext = WEW'(width_q);
		h_ext = HEW'(height_q);
		if (width_q == '0) begin
			w_eff = WSW'(1);
		end else if (w_ext > WEW'(MAX_WIDTH)) begin
			w_eff = WSW'(MAX_WIDTH);
		end else begin
			w_eff = WSW'(w_ext);
		end
		if (height_q == '0) begin
			h_eff = HSW'(1);
		end else if (h_ext > HEW'(MAX_HEIGHT)) begin
			h_eff = HSW'(MAX_HEIGHT);
		end else begin
			h_eff = HSW'(h_ext);
		end
	end

	assign last_col  = WSW'(col_q) >= (w_eff - WSW'(1));
	assign last_row  = HSW'(row_q) >= (h_eff - HSW'(1));
	assign even_col  = ~col_q[0];
	assign even_row  = ~row_q[0];
	assign pair_done = ~even_col | last_col;
	assign pr        = even_col ? {red, 1'b0}   : PAIR_W'(pend_r_q) + PAIR_W'(red);
	assign pg        = even_col ? {green, 1'b0} : PAIR_W'(pend_g_q) + PAIR_W'(green);
	assign pb        = even_col ? {blue, 1'b0}  : PAIR_W'(pend_b_q) + PAIR_W'(blue);
	assign seen      = flag_q | (alpha != '1);
	assign store     = accept & pair_done & even_row & ~last_row;
	assign line_addr = AW'(col_q >> 1);

	rgbyuv_ram #(
		.WIDTH(LINE_W),
		.DEPTH(LINE_DEPTH)
	) u_line (
		.clk  (clk),
		.we   (store),
		.waddr(line_addr),
		.wdata({pb, pg, pr}),
		.re   (accept),
		.raddr(line_addr),
		.rdata(line_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q        <= WIDTH_RESET;
			height_q       <= HEIGHT_RESET;
			col_q          <= '0;
			row_q          <= '0;
			flag_q         <= 1'b0;
			pend_r_q       <= '0;
			pend_g_q       <= '0;
			pend_b_q       <= '0;
			stage_s1       <= '0;
		end else begin
			stage_s1.valid <= accept;
			if (cfg_we) begin
				case (cfg_index)
					REG_IMAGE_WIDTH:  width_q  <= cfg_data;
					REG_IMAGE_HEIGHT: height_q <= cfg_data;
					default:          width_q  <= width_q;
				endcase
			end
			if (accept) begin
				stage_s1.red       <= red;
				stage_s1.green     <= green;
				stage_s1.blue      <= blue;
				stage_s1.alpha     <= alpha;
				stage_s1.pair_r    <= pr;
				stage_s1.pair_g    <= pg;
				stage_s1.pair_b    <= pb;
				stage_s1.odd_row   <= ~even_row;
				stage_s1.emit      <= pair_done & (~even_row | last_row);
				stage_s1.seen      <= seen;
				stage_s1.frame_end <= last_col & last_row;
				if (even_col && !last_col) begin
					pend_r_q <= red;
					pend_g_q <= green;
					pend_b_q <= blue;
				end
				if (last_col) begin
					col_q <= '0;
					if (last_row) begin
						row_q  <= '0;
						flag_q <= 1'b0;
					end else begin
						row_q  <= row_q + RW'(1);
						flag_q <= seen;
					end
				end else begin
					col_q  <= col_q + CW'(1);
					flag_q <= seen;
				end
			end
		end
	end

endmodule

>>> design/rgbyuv_math.sv
// ----------------------------------------------------------------------------
// rgbyuv_math
// Block sums, constant-coefficient products, and luma and chroma rounding
// with clipping.
// ----------------------------------------------------------------------------
module rgbyuv_math (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rgbyuv_pkg::rgbyuv_s1_t        stage_s1,
	input  logic [rgbyuv_pkg::LINE_W-1:0] line_rdata,
	output logic                          push,
	output rgbyuv_pkg::rgbyuv_res_t       result,
	output logic [1:0]                    inflight
);

	import rgbyuv_pkg::*;

	logic [BLK_W-1:0]  rs;
	logic [BLK_W-1:0]  gs;
	logic [BLK_W-1:0]  bs;

	logic              valid_s2;
	logic [BLK_W-1:0]  rs_s2;
	logic [BLK_W-1:0]  gs_s2;
	logic [BLK_W-1:0]  bs_s2;
	logic [PIX_W-1:0]  red_s2;
	logic [PIX_W-1:0]  green_s2;
	logic [PIX_W-1:0]  blue_s2;
	logic [PIX_W-1:0]  alpha_s2;
	logic              emit_s2;
	logic              seen_s2;
	logic              fe_s2;

	logic              valid_s3;
	logic [PROD_W-1:0] yr_s3;
	logic [PROD_W-1:0] yg_s3;
	logic [PROD_W-1:0] yb_s3;
	logic [PROD_W-1:0] ur_s3;
	logic [PROD_W-1:0] ug_s3;
	logic [PROD_W-1:0] ub_s3;
	logic [PROD_W-1:0] vr_s3;
	logic [PROD_W-1:0] vg_s3;
	logic [PROD_W-1:0] vb_s3;
	logic [PIX_W-1:0]  alpha_s3;
	logic              emit_s3;
	logic              seen_s3;
	logic              fe_s3;

	logic [PROD_W-1:0]       y_sum;
	logic signed [ACC_W-1:0] u_acc;
	logic signed [ACC_W-1:0] v_acc;

	always_comb begin
		if (stage_s1.odd_row) begin
			rs = BLK_W'(line_rdata[PAIR_W-1:0])          + BLK_W'(stage_s1.pair_r);
			gs = BLK_W'(line_rdata[2*PAIR_W-1:PAIR_W])   + BLK_W'(stage_s1.pair_g);
			bs = BLK_W'(line_rdata[3*PAIR_W-1:2*PAIR_W]) + BLK_W'(stage_s1.pair_b);
		end else begin
			rs = {stage_s1.pair_r, 1'b0};
			gs = {stage_s1.pair_g, 1'b0};
			bs = {stage_s1.pair_b, 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s2 <= stage_s1.valid;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		rs_s2    <= rs;
		gs_s2    <= gs;
		bs_s2    <= bs;
		red_s2   <= stage_s1.red;
		green_s2 <= stage_s1.green;
		blue_s2  <= stage_s1.blue;
		alpha_s2 <= stage_s1.alpha;
		emit_s2  <= stage_s1.emit;
		seen_s2  <= stage_s1.seen;
		fe_s2    <= stage_s1.frame_end;

		yr_s3    <= PROD_W'(red_s2)   * PROD_W'(Y_R);
		yg_s3    <= PROD_W'(green_s2) * PROD_W'(Y_G);
		yb_s3    <= PROD_W'(blue_s2)  * PROD_W'(Y_B);
		ur_s3    <= PROD_W'(rs_s2) * PROD_W'(U_R);
		ug_s3    <= PROD_W'(gs_s2) * PROD_W'(U_G);
		ub_s3    <= PROD_W'(bs_s2) * PROD_W'(U_B);
		vr_s3    <= PROD_W'(rs_s2) * PROD_W'(V_R);
		vg_s3    <= PROD_W'(gs_s2) * PROD_W'(V_G);
		vb_s3    <= PROD_W'(bs_s2) * PROD_W'(V_B);
		alpha_s3 <= alpha_s2;
		emit_s3  <= emit_s2;
		seen_s3  <= seen_s2;
		fe_s3    <= fe_s2;
	end

	assign y_sum = yr_s3 + yg_s3 + yb_s3 + Y_OFFSET;
	assign u_acc = $signed(ACC_W'(ub_s3)) - $signed(ACC_W'(ur_s3))
		- $signed(ACC_W'(ug_s3)) + $signed(C_OFFSET);
	assign v_acc = $signed(ACC_W'(vr_s3)) - $signed(ACC_W'(vg_s3))
		- $signed(ACC_W'(vb_s3)) + $signed(C_OFFSET);

	always_comb begin
		result.luma         = y_sum[LUMA_SHIFT+PIX_W-1:LUMA_SHIFT];
		result.alpha        = alpha_s3;
		result.chroma_valid = emit_s3;
		result.chroma_u     = emit_s3 ? chroma_clip(u_acc) : '0;
		result.chroma_v     = emit_s3 ? chroma_clip(v_acc) : '0;
		result.seen         = seen_s3;
		result.frame_end    = fe_s3;
	end

	assign push     = valid_s3;
	assign inflight = {1'b0, valid_s2} + {1'b0, valid_s3};

endmodule

>>> design/rgbyuv_fifo.sv
// ----------------------------------------------------------------------------
// rgbyuv_fifo
// Small register queue that holds finished results until the sink takes them.
// ----------------------------------------------------------------------------
module rgbyuv_fifo #(
	parameter int WIDTH = 35
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  logic [WIDTH-1:0]             wdata,
	input  logic                         pop,
	output logic [WIDTH-1:0]             rdata,
	output logic                         not_empty,
	output logic [rgbyuv_pkg::FIFO_PW:0] count
);

	import rgbyuv_pkg::*;

	logic [WIDTH-1:0]   mem_q [FIFO_DEPTH];
	logic [FIFO_PW-1:0] wr_ptr_q;
	logic [FIFO_PW-1:0] rd_ptr_q;
	logic [FIFO_PW:0]   count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + FIFO_PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_PW'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + (FIFO_PW+1)'(1);
				2'b01:   count_q <= count_q - (FIFO_PW+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	assign rdata     = mem_q[rd_ptr_q];
	assign not_empty = count_q != '0;
	assign count     = count_q;

endmodule

>>> design/rgb_to_yuv420_converter_unit.sv
// ----------------------------------------------------------------------------
// rgb_to_yuv420_converter_unit
// BT.601 limited-range RGBA to YUV 4:2:0 converter for raster-order pixels.
// ----------------------------------------------------------------------------
// The unit takes one pixel per clock while s_tready is high and gives one
// result per pixel, with U and V on the pixel that completes each 2x2
// block. A result passes the s1, s2 and s3 registers into the output queue,
// which it can leave in the cycle after the write; the queue holds eight
// results, and the input stays ready as long as the queue and the three
// arithmetic stages together have room, so the sustained rate is one pixel
// per clock whenever the sink takes one result per clock. Even-row pair
// sums live in a single line store of (MAX_WIDTH + 1) / 2 entries that is
// read and written at most once per pixel; it needs no clearing pass after
// reset. Size registers may only be written while the unit is idle.
module rgb_to_yuv420_converter_unit #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [0:0]                   cfg_index,
	input  logic [rgbyuv_pkg::CFG_W-1:0] cfg_data,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [31:0]                  s_tdata,   // red, green, blue, alpha
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// luma, alpha_out, chroma_u, chroma_v, transparent_seen, zero fill
	output logic [39:0]                  m_tdata,
	output logic                         m_tuser,   // chroma_valid
	output logic                         m_tlast    // frame_end
);

	import rgbyuv_pkg::*;

	localparam int RES_W = $bits(rgbyuv_res_t);

	rgbyuv_s1_t        stage_s1;
	logic [LINE_W-1:0] line_rdata;
	logic              accept;
	logic              push;
	logic              pop;
	rgbyuv_res_t       result;
	rgbyuv_res_t       head;
	logic [RES_W-1:0]  head_bits;
	logic [1:0]        inflight;
	logic [FIFO_PW:0]  fifo_count;
	logic [FIFO_PW+1:0] used;

	assign used     = (FIFO_PW+2)'(fifo_count) + (FIFO_PW+2)'(stage_s1.valid)
		+ (FIFO_PW+2)'(inflight);
	assign s_tready = used < (FIFO_PW+2)'(FIFO_DEPTH);
	assign accept   = s_tvalid & s_tready;
	assign pop      = m_tvalid & m_tready;

	rgbyuv_front #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.red       (s_tdata[7:0]),
		.green     (s_tdata[15:8]),
		.blue      (s_tdata[23:16]),
		.alpha     (s_tdata[31:24]),
		.stage_s1  (stage_s1),
		.line_rdata(line_rdata)
	);

	rgbyuv_math u_math (
		.clk       (clk),
		.arst_n    (arst_n),
		.stage_s1  (stage_s1),
		.line_rdata(line_rdata),
		.push      (push),
		.result    (result),
		.inflight  (inflight)
	);

	rgbyuv_fifo #(
		.WIDTH(RES_W)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wdata    (result),
		.pop      (pop),
		.rdata    (head_bits),
		.not_empty(m_tvalid),
		.count    (fifo_count)
	);

	assign head    = rgbyuv_res_t'(head_bits);
	assign m_tdata = {7'b0, head.seen, head.chroma_v, head.chroma_u, head.alpha, head.luma};
	assign m_tuser = head.chroma_valid;
	assign m_tlast = head.frame_end;

endmodule

>>> design/rgbyuv_checker.sv
// ----------------------------------------------------------------------------
// rgbyuv_checker
// Port-level assertions for the RGB to YUV 4:2:0 converter.
// ----------------------------------------------------------------------------
module rgbyuv_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata,
	input logic        m_tuser,
	input logic        m_tlast
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("Result valid dropped before its transfer.");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
		else $error("Result changed while stalled.");

	a_no_chroma: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[31:16] == 16'h0000)
		else $error("Chroma is nonzero on a pixel that completes no block.");

	a_last_block: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser)
		else $error("The last pixel of a frame did not complete a block.");

endmodule

bind rgb_to_yuv420_converter_unit rgbyuv_checker u_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser),
	.m_tlast (m_tlast)
);
